// ===== hw/rtl/vae_pkg.sv =====
// vae_pkg: shared types, constants and helpers for the vitals alarm escalation block
// used by every module under hw/rtl, depends on nothing
package vae_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 20;

  localparam logic [CFG_INDEX_W-1:0] REG_HEART_THRESHOLD  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BREATH_THRESHOLD = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE_TIME_MS = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_DISTANCE_GATE_ON = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_DISTANCE_MM  = 3'd4;

  localparam logic [11:0] HEART_THRESHOLD_RST  = 12'd400;
  localparam logic [9:0]  BREATH_THRESHOLD_RST = 10'd60;
  localparam logic [19:0] DEBOUNCE_TIME_RST    = 20'd15000;
  localparam logic        DISTANCE_GATE_RST    = 1'b1;
  localparam logic [15:0] MAX_DISTANCE_RST     = 16'd1500;

  localparam logic [31:0] PRIMARY_DELAY_MS = 32'd45000;
  localparam logic [31:0] FAMILY_DELAY_MS  = 32'd60000;
  localparam logic [31:0] COOLDOWN_MS      = 32'd30000;
  localparam logic [16:0] ROUND_UP_MS      = 17'd999;

  // floor(y / 1000) = (y * 67109) >> 26, exact for y below 2^16
  localparam logic [16:0] RECIP_1000  = 17'd67109;
  localparam int          RECIP_SHIFT = 26;

  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 24;

  typedef enum logic [2:0] {
    MODE_IDLE     = 3'd0,
    MODE_DEBOUNCE = 3'd1,
    MODE_PENDING  = 3'd2,
    MODE_WAITING  = 3'd3,
    MODE_COOLDOWN = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    CMD_TICK         = 2'd0,
    CMD_CANCEL       = 2'd1,
    CMD_PRIMARY_DONE = 2'd2,
    CMD_FAMILY_DONE  = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [11:0] heart_threshold;
    logic [9:0]  breath_threshold;
    logic [19:0] debounce_time_ms;
    logic        distance_gate_on;
    logic [15:0] max_distance_mm;
  } cfg_t;

  typedef struct packed {
    cmd_t        command;
    logic [31:0] now_ms;
    logic [11:0] heart_rate;
    logic        heart_ok;
    logic [9:0]  breath_rate;
    logic        breath_ok;
    logic [15:0] distance_mm;
    logic        distance_ok;
  } item_t;

  typedef struct packed {
    logic [2:0] alarm_state;
    logic [5:0] seconds_to_primary;
    logic [5:0] seconds_to_family;
    logic       primary_due;
    logic       family_due;
  } result_t;

  // whole seconds left, rounded up, zero once the delay has passed
  function automatic logic [5:0] secs_left(input logic [31:0] el, input logic [31:0] delay);
    logic [15:0] rem;
    logic [16:0] y;
    logic [33:0] prod;
    rem  = delay[15:0] - el[15:0];
    y    = {1'b0, rem} + ROUND_UP_MS;
    prod = y * RECIP_1000;
    if (el >= delay) begin
      return 6'd0;
    end
    return prod[RECIP_SHIFT+5:RECIP_SHIFT];
  endfunction

endpackage

// ===== hw/rtl/vae_cfg_regs.sv =====
// vae_cfg_regs: configuration register file written through the cfg channel
// depends on vae_pkg
module vae_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            wr_en,
  input  logic [vae_pkg::CFG_INDEX_W-1:0] wr_index,
  input  logic [vae_pkg::CFG_DATA_W-1:0]  wr_data,
  output vae_pkg::cfg_t                   cfg
);

  vae_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.heart_threshold  <= vae_pkg::HEART_THRESHOLD_RST;
      cfg_r.breath_threshold <= vae_pkg::BREATH_THRESHOLD_RST;
      cfg_r.debounce_time_ms <= vae_pkg::DEBOUNCE_TIME_RST;
      cfg_r.distance_gate_on <= vae_pkg::DISTANCE_GATE_RST;
      cfg_r.max_distance_mm  <= vae_pkg::MAX_DISTANCE_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        vae_pkg::REG_HEART_THRESHOLD:  cfg_r.heart_threshold  <= wr_data[11:0];
        vae_pkg::REG_BREATH_THRESHOLD: cfg_r.breath_threshold <= wr_data[9:0];
        vae_pkg::REG_DEBOUNCE_TIME_MS: cfg_r.debounce_time_ms <= wr_data[19:0];
        vae_pkg::REG_DISTANCE_GATE_ON: cfg_r.distance_gate_on <= wr_data[0];
        vae_pkg::REG_MAX_DISTANCE_MM:  cfg_r.max_distance_mm  <= wr_data[15:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== hw/rtl/vae_core.sv =====
// vae_core: escalation state registers and the single-pass next-state and result logic
// depends on vae_pkg
module vae_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  vae_pkg::cfg_t    cfg,
  input  vae_pkg::item_t   item,
  output vae_pkg::result_t result
);

  vae_pkg::mode_t mode_r, mode_nxt;
  logic [31:0] low_since_r, low_since_nxt;
  logic [31:0] alarm_entered_r, alarm_entered_nxt;
  logic        primary_done_r, primary_done_nxt;
  logic        family_done_r, family_done_nxt;
  logic [31:0] primary_done_at_r, primary_done_at_nxt;
  logic [31:0] cooldown_end_r, cooldown_end_nxt;

  logic        low;
  logic [31:0] cool_diff;
  logic [31:0] el_primary;
  logic [31:0] el_family;
  logic        show_primary;
  logic        show_family;

  assign low = item.heart_ok && item.breath_ok &&
               (item.heart_rate < cfg.heart_threshold) &&
               (item.breath_rate < cfg.breath_threshold) &&
               (!cfg.distance_gate_on ||
                (item.distance_ok && (item.distance_mm <= cfg.max_distance_mm)));

  assign cool_diff = item.now_ms - cooldown_end_r;

  always_comb begin
    mode_nxt            = mode_r;
    low_since_nxt       = low_since_r;
    alarm_entered_nxt   = alarm_entered_r;
    primary_done_nxt    = primary_done_r;
    family_done_nxt     = family_done_r;
    primary_done_at_nxt = primary_done_at_r;
    cooldown_end_nxt    = cooldown_end_r;
    unique case (item.command)
      vae_pkg::CMD_TICK: begin
        unique case (mode_r)
          vae_pkg::MODE_IDLE: begin
            if (low) begin
              low_since_nxt = item.now_ms;
              mode_nxt      = vae_pkg::MODE_DEBOUNCE;
            end
          end
          vae_pkg::MODE_DEBOUNCE: begin
            if (!low) begin
              mode_nxt = vae_pkg::MODE_IDLE;
            end else if ((item.now_ms - low_since_r) >= {12'd0, cfg.debounce_time_ms}) begin
              alarm_entered_nxt = item.now_ms;
              primary_done_nxt  = 1'b0;
              family_done_nxt   = 1'b0;
              mode_nxt          = vae_pkg::MODE_PENDING;
            end
          end
          vae_pkg::MODE_PENDING: begin
            if (!low) begin
              mode_nxt            = vae_pkg::MODE_IDLE;
              low_since_nxt       = '0;
              alarm_entered_nxt   = '0;
              primary_done_nxt    = 1'b0;
              family_done_nxt     = 1'b0;
              primary_done_at_nxt = '0;
              cooldown_end_nxt    = '0;
            end
          end
          vae_pkg::MODE_COOLDOWN: begin
            if (!cool_diff[31]) begin
              mode_nxt            = vae_pkg::MODE_IDLE;
              low_since_nxt       = '0;
              alarm_entered_nxt   = '0;
              primary_done_nxt    = 1'b0;
              family_done_nxt     = 1'b0;
              primary_done_at_nxt = '0;
              cooldown_end_nxt    = '0;
            end
          end
          default: ;
        endcase
      end
      vae_pkg::CMD_CANCEL: begin
        mode_nxt            = vae_pkg::MODE_IDLE;
        low_since_nxt       = '0;
        alarm_entered_nxt   = '0;
        primary_done_nxt    = 1'b0;
        family_done_nxt     = 1'b0;
        primary_done_at_nxt = '0;
        cooldown_end_nxt    = '0;
      end
      vae_pkg::CMD_PRIMARY_DONE: begin
        primary_done_nxt    = 1'b1;
        primary_done_at_nxt = item.now_ms;
        mode_nxt            = vae_pkg::MODE_WAITING;
      end
      vae_pkg::CMD_FAMILY_DONE: begin
        family_done_nxt  = 1'b1;
        cooldown_end_nxt = item.now_ms + vae_pkg::COOLDOWN_MS;
        mode_nxt         = vae_pkg::MODE_COOLDOWN;
      end
      default: ;
    endcase
  end

  assign el_primary   = item.now_ms - alarm_entered_nxt;
  assign el_family    = item.now_ms - primary_done_at_nxt;
  assign show_primary = (mode_nxt == vae_pkg::MODE_PENDING) && !primary_done_nxt;
  assign show_family  = (mode_nxt == vae_pkg::MODE_WAITING) && !family_done_nxt;

  always_comb begin
    result.alarm_state        = mode_nxt;
    result.seconds_to_primary = show_primary ?
                                vae_pkg::secs_left(el_primary, vae_pkg::PRIMARY_DELAY_MS) : 6'd0;
    result.seconds_to_family  = show_family ?
                                vae_pkg::secs_left(el_family, vae_pkg::FAMILY_DELAY_MS) : 6'd0;
    result.primary_due        = show_primary && (el_primary >= vae_pkg::PRIMARY_DELAY_MS);
    result.family_due         = show_family && (el_family >= vae_pkg::FAMILY_DELAY_MS);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r            <= vae_pkg::MODE_IDLE;
      low_since_r       <= '0;
      alarm_entered_r   <= '0;
      primary_done_r    <= 1'b0;
      family_done_r     <= 1'b0;
      primary_done_at_r <= '0;
      cooldown_end_r    <= '0;
    end else if (en) begin
      mode_r            <= mode_nxt;
      low_since_r       <= low_since_nxt;
      alarm_entered_r   <= alarm_entered_nxt;
      primary_done_r    <= primary_done_nxt;
      family_done_r     <= family_done_nxt;
      primary_done_at_r <= primary_done_at_nxt;
      cooldown_end_r    <= cooldown_end_nxt;
    end
  end

endmodule

// ===== hw/rtl/vitals_alarm_escalation_top.sv =====
// vitals_alarm_escalation_top: input register, escalation core, result register
// data path: an item's result is registered as the item leaves the input register
// throughput: one item per cycle unless out_tready stalls, set by the vae_core pass
// reset: synchronous active-low rst_n empties both registers, sets state to idle
// and loads the default thresholds; config writes are taken every cycle
// depends on vae_pkg, vae_cfg_regs, vae_core
module vitals_alarm_escalation_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // now_ms, heart_rate, heart_ok, breath_rate, breath_ok, distance_mm, distance_ok
  input  logic [vae_pkg::IN_TDATA_W-1:0]   in_tdata,
  // command
  input  logic [1:0]                       in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // alarm_state, seconds_to_primary, seconds_to_family, primary_due, family_due
  output logic [vae_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [vae_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [vae_pkg::CFG_DATA_W-1:0]   cfg_data
);

  vae_pkg::cfg_t    cfg;
  vae_pkg::item_t   item_r;
  vae_pkg::result_t result;
  logic             in_valid_r;
  logic             out_valid_r;
  logic [vae_pkg::OUT_TDATA_W-1:0] out_tdata_r;
  logic             advance;

  assign cfg_ready = 1'b1;

  vae_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r.command     <= vae_pkg::cmd_t'(in_tuser);
      item_r.now_ms      <= in_tdata[31:0];
      item_r.heart_rate  <= in_tdata[43:32];
      item_r.heart_ok    <= in_tdata[44];
      item_r.breath_rate <= in_tdata[54:45];
      item_r.breath_ok   <= in_tdata[55];
      item_r.distance_mm <= in_tdata[71:56];
      item_r.distance_ok <= in_tdata[72];
    end
  end

  vae_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (advance),
    .cfg    (cfg),
    .item   (item_r),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_tdata_r <= {7'd0, result.family_due, result.primary_due,
                      result.seconds_to_family, result.seconds_to_primary,
                      result.alarm_state};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;

endmodule
